/* hw/rtl/double_ended_queue_defines.svh */
// Assertion macros for the double-ended queue checker.
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

// Checks a property at every rising clock edge outside of reset.
`define DEQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Checks a property at every rising clock edge, reset included.
`define DEQ_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* hw/rtl/deq_pkg.sv */
// Types and constants shared by the double-ended queue modules.
package deq_pkg;

    localparam int DEQ_DEPTH = 64;
    localparam int DEQ_OCC_W = 7;

    typedef enum logic [1:0] {
        MODE_PUSH_BACK  = 2'd0,
        MODE_PUSH_FRONT = 2'd1,
        MODE_POP_BACK   = 2'd2,
        MODE_POP_FRONT  = 2'd3
    } deq_mode_t;

    typedef enum logic [1:0] {
        ERR_OK        = 2'd0,
        ERR_UNDERFLOW = 2'd1,
        ERR_OVERFLOW  = 2'd2
    } deq_err_t;

    typedef enum logic [1:0] {
        CH_HOLD   = 2'd0,
        CH_INSERT = 2'd1,
        CH_REMOVE = 2'd2,
        CH_APPEND = 2'd3
    } deq_chain_op_t;

    typedef struct packed {
        deq_chain_op_t      op;
        logic signed [31:0] value;
    } deq_chain_ctl_t;

    typedef struct packed {
        deq_mode_t          mode;
        logic signed [31:0] value;
    } deq_cmd_t;

    typedef struct packed {
        logic signed [31:0]     popped_value;
        logic signed [31:0]     front_value;
        logic signed [31:0]     back_value;
        logic [DEQ_OCC_W-1:0]   occupancy;
        logic                   is_empty;
        deq_err_t               error_code;
    } deq_result_t;

endpackage

/* hw/rtl/deq_cell.sv */
// One storage cell of a deque chain, loaded from a neighbor or from the pushed value.
module deq_cell #(
    parameter int DEPTH = 64,
    parameter int INDEX = 0,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                  clk,
    input  deq_pkg::deq_chain_ctl_t ctl,
    input  logic [CNT_W-1:0]      count,
    input  logic signed [31:0]    lower_data,
    input  logic signed [31:0]    upper_data,
    output logic signed [31:0]    data
);
    import deq_pkg::*;

    logic signed [31:0] data_reg;
    logic signed [31:0] data_next;

    always_comb
    begin
        case (ctl.op)
            CH_INSERT: data_next = lower_data;
            CH_REMOVE: data_next = upper_data;
            CH_APPEND: data_next = (count == CNT_W'(INDEX)) ? ctl.value : data_reg;
            default:   data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

/* hw/rtl/deq_chain.sv */
// A row of deque cells with one end fixed at cell zero.
module deq_chain #(
    parameter int DEPTH = 64,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                    clk,
    input  deq_pkg::deq_chain_ctl_t ctl,
    input  logic [CNT_W-1:0]        count,
    output logic signed [31:0]      head0,
    output logic signed [31:0]      head1
);
    import deq_pkg::*;

    logic signed [31:0] cell_data [DEPTH];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [31:0] lower;
        logic signed [31:0] upper;

        if (i == 0)
        begin : g_first
            assign lower = ctl.value;
        end
        else
        begin : g_mid_low
            assign lower = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign upper = '0;
        end
        else
        begin : g_mid_up
            assign upper = cell_data[i+1];
        end

        deq_cell #(
            .DEPTH (DEPTH),
            .INDEX (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .count      (count),
            .lower_data (lower),
            .upper_data (upper),
            .data       (cell_data[i])
        );
    end

    assign head0 = cell_data[0];
    assign head1 = cell_data[1];

endmodule

/* hw/rtl/double_ended_queue.sv */
// Top level of the double-ended queue of signed 32-bit values.
// The queue takes one transaction in every clock cycle and returns its result in the next
// cycle, marked by done; busy never rises and the result holds until the next transaction.
// Two rows of cells hold the entries, one with the front and one with the back at its first
// cell; a push shifts one row and loads the other, a pop shifts one, and the front, back
// and popped values come from the first two cells of the rows or from the pushed value.
module double_ended_queue #(
    parameter int DEPTH = deq_pkg::DEQ_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  deq_pkg::deq_cmd_t    cmd,
    output logic                 busy,
    output logic                 done,
    output deq_pkg::deq_result_t result
);
    import deq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             done_reg;
    deq_result_t      result_reg;
    deq_result_t      result_next;

    deq_chain_ctl_t   front_ctl;
    deq_chain_ctl_t   back_ctl;
    logic signed [31:0] f0;
    logic signed [31:0] f1;
    logic signed [31:0] b0;
    logic signed [31:0] b1;

    logic accept;
    logic is_push;
    logic full;
    logic empty;
    logic ok;
    logic signed [31:0] front_new;
    logic signed [31:0] back_new;

    assign accept = start && !busy;
    assign full   = (count_reg == CNT_W'(DEPTH));
    assign empty  = (count_reg == '0);

    always_comb
    begin
        is_push     = cmd.mode inside {MODE_PUSH_BACK, MODE_PUSH_FRONT};
        ok          = is_push ? !full : !empty;
        count_next  = count_reg;
        front_ctl   = '{op: CH_HOLD, value: cmd.value};
        back_ctl    = '{op: CH_HOLD, value: cmd.value};
        front_new   = f0;
        back_new    = b0;
        result_next = '0;

        if (ok)
        begin
            case (cmd.mode)
                MODE_PUSH_BACK:
                begin
                    count_next   = count_reg + 1'b1;
                    front_ctl.op = CH_APPEND;
                    back_ctl.op  = CH_INSERT;
                    front_new    = empty ? cmd.value : f0;
                    back_new     = cmd.value;
                end
                MODE_PUSH_FRONT:
                begin
                    count_next   = count_reg + 1'b1;
                    front_ctl.op = CH_INSERT;
                    back_ctl.op  = CH_APPEND;
                    front_new    = cmd.value;
                    back_new     = empty ? cmd.value : b0;
                end
                MODE_POP_BACK:
                begin
                    count_next   = count_reg - 1'b1;
                    back_ctl.op  = CH_REMOVE;
                    back_new     = b1;
                    result_next.popped_value = b0;
                end
                MODE_POP_FRONT:
                begin
                    count_next   = count_reg - 1'b1;
                    front_ctl.op = CH_REMOVE;
                    front_new    = f1;
                    result_next.popped_value = f0;
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end

        if (!accept)
        begin
            front_ctl.op = CH_HOLD;
            back_ctl.op  = CH_HOLD;
            count_next   = count_reg;
        end

        result_next.is_empty   = (count_next == '0);
        result_next.occupancy  = DEQ_OCC_W'(count_next);
        result_next.front_value = result_next.is_empty ? '0 : front_new;
        result_next.back_value  = result_next.is_empty ? '0 : back_new;
        if (ok)
        begin
            result_next.error_code = ERR_OK;
        end
        else if (is_push)
        begin
            result_next.error_code = ERR_OVERFLOW;
        end
        else
        begin
            result_next.error_code = ERR_UNDERFLOW;
        end
    end

    deq_chain #(
        .DEPTH (DEPTH),
        .CNT_W (CNT_W)
    ) u_front_chain (
        .clk   (clk),
        .ctl   (front_ctl),
        .count (count_reg),
        .head0 (f0),
        .head1 (f1)
    );

    deq_chain #(
        .DEPTH (DEPTH),
        .CNT_W (CNT_W)
    ) u_back_chain (
        .clk   (clk),
        .ctl   (back_ctl),
        .count (count_reg),
        .head0 (b0),
        .head1 (b1)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign busy   = 1'b0;
    assign done   = done_reg;
    assign result = result_reg;

endmodule

/* hw/rtl/deq_checker.sv */
// Port-level checker for the double-ended queue and its bind to the top level.
`include "double_ended_queue_defines.svh"

module deq_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 start,
    input deq_pkg::deq_cmd_t    cmd,
    input logic                 busy,
    input logic                 done,
    input deq_pkg::deq_result_t result
);
    import deq_pkg::*;

    logic taken;

    assign taken = start && !busy && (cmd.mode == cmd.mode);

    // Every accepted transaction yields exactly one result in the following cycle.
    `DEQ_ASSERT(a_result_follows, taken |=> done, "accepted transaction gave no result")
    `DEQ_ASSERT(a_no_spurious, !taken |=> !done, "result without an accepted transaction")
    // An empty queue reports no entries and zero end values.
    `DEQ_ASSERT(a_empty_fields,
        done && result.is_empty |-> result.front_value == 0 && result.back_value == 0
            && result.occupancy == 0, "empty result carries stale fields")
    // Underflow leaves the queue empty and removes nothing.
    `DEQ_ASSERT(a_underflow,
        done && result.error_code == ERR_UNDERFLOW |-> result.is_empty
            && result.popped_value == 0, "underflow with a non-empty queue")
    `DEQ_ASSERT_ALWAYS(a_overflow,
        !rst_n || !done || result.error_code != ERR_OVERFLOW || !result.is_empty,
        "overflow reported on an empty queue")

endmodule

bind double_ended_queue deq_checker u_deq_checker (.*);

/* dv/double_ended_queue_test.sv */
// Self-checking testbench for the double-ended queue with a built-in predictor.
module double_ended_queue_test;
    import deq_pkg::*;

    localparam int PTR_W = $clog2(DEQ_DEPTH);
    localparam int CYCLE_LIMIT = 300000;

    logic        clk;
    logic        rst_n;
    logic        start;
    deq_cmd_t    cmd;
    logic        busy;
    logic        done;
    deq_result_t result;

    logic signed [31:0] held_values [DEQ_DEPTH];
    logic [PTR_W-1:0]   front_ptr;
    logic [PTR_W-1:0]   back_ptr;
    int                 held_count;

    deq_result_t pending_results [$];
    int          mismatches;
    int          idle_pct;
    int          cycles;

    double_ended_queue dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Applies one transaction to the shadow queue and returns the result it should give.
    function automatic deq_result_t apply_cmd(deq_cmd_t c);
        deq_result_t      r;
        logic [PTR_W-1:0] last_ptr;
        r = '0;
        r.error_code = ERR_OK;
        case (c.mode)
            MODE_PUSH_BACK, MODE_PUSH_FRONT:
            begin
                if (held_count >= DEQ_DEPTH)
                begin
                    r.error_code = ERR_OVERFLOW;
                end
                else if (c.mode == MODE_PUSH_BACK)
                begin
                    held_values[back_ptr] = c.value;
                    back_ptr = back_ptr + 1'b1;
                    held_count++;
                end
                else
                begin
                    front_ptr = front_ptr - 1'b1;
                    held_values[front_ptr] = c.value;
                    held_count++;
                end
            end
            default:
            begin
                if (held_count == 0)
                begin
                    r.error_code = ERR_UNDERFLOW;
                end
                else if (c.mode == MODE_POP_BACK)
                begin
                    back_ptr = back_ptr - 1'b1;
                    r.popped_value = held_values[back_ptr];
                    held_count--;
                end
                else
                begin
                    r.popped_value = held_values[front_ptr];
                    front_ptr = front_ptr + 1'b1;
                    held_count--;
                end
            end
        endcase
        if (held_count != 0)
        begin
            last_ptr = back_ptr - 1'b1;
            r.front_value = held_values[front_ptr];
            r.back_value = held_values[last_ptr];
        end
        r.occupancy = DEQ_OCC_W'(held_count);
        r.is_empty = (held_count == 0);
        return r;
    endfunction

    function automatic logic [31:0] random_value();
        case ($urandom_range(7))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_cmd(deq_mode_t mode, logic [31:0] value);
        deq_cmd_t c;
        c.mode = mode;
        c.value = value;
        start <= 1'b1;
        cmd <= c;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        pending_results.push_back(apply_cmd(c));
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            do
            begin
                @(posedge clk);
            end
            while ($urandom_range(99) < idle_pct);
        end
    endtask

    task automatic send_push(logic [31:0] value);
        send_cmd($urandom_range(1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK, value);
    endtask

    task automatic send_pop();
        send_cmd($urandom_range(1) ? MODE_POP_FRONT : MODE_POP_BACK, $urandom);
    endtask

    task automatic test_corner_values();
        send_cmd(MODE_PUSH_BACK, 32'h7fff_ffff);
        send_cmd(MODE_PUSH_FRONT, 32'h8000_0000);
        send_cmd(MODE_PUSH_BACK, 32'h0000_0000);
        send_cmd(MODE_PUSH_FRONT, 32'hffff_ffff);
        send_cmd(MODE_POP_FRONT, 32'h1234_5678);
        send_cmd(MODE_POP_BACK, 32'hffff_ffff);
        send_cmd(MODE_POP_FRONT, 32'h0000_0000);
        send_cmd(MODE_POP_BACK, 32'h8000_0000);
        send_cmd(MODE_PUSH_BACK, 32'h5555_5555);
        send_cmd(MODE_PUSH_FRONT, 32'haaaa_aaaa);
        send_cmd(MODE_POP_BACK, 32'h0);
        send_cmd(MODE_POP_BACK, 32'h0);
    endtask

    task automatic test_empty_pops();
        send_cmd(MODE_POP_BACK, 32'hffff_ffff);
        send_cmd(MODE_POP_FRONT, 32'h7fff_ffff);
        send_cmd(MODE_PUSH_FRONT, 32'h0000_0001);
        send_cmd(MODE_POP_FRONT, 32'h0);
        send_cmd(MODE_POP_FRONT, 32'h0);
    endtask

    // Fills the queue until it is full, pushes past full, then drains it and pops past empty.
    task automatic test_fill_and_drain();
        while (held_count < DEQ_DEPTH)
        begin
            if (held_count > 0 && $urandom_range(9) == 0)
                send_pop();
            else
                send_push(random_value());
        end
        repeat (3) send_push(random_value());
        while (held_count > 0)
        begin
            if ($urandom_range(9) == 0)
                send_push(random_value());
            else
                send_pop();
        end
        repeat (3) send_pop();
    endtask

    task automatic test_random_mix(int count);
        repeat (count)
        begin
            send_cmd(deq_mode_t'($urandom_range(3)), random_value());
        end
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        deq_result_t want;
        if (rst_n && done !== 1'b0)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result expected none actual %h", $time, result);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("popped_value", want.popped_value, result.popped_value);
                check_field("front_value", want.front_value, result.front_value);
                check_field("back_value", want.back_value, result.back_value);
                check_field("occupancy", want.occupancy, result.occupancy);
                check_field("is_empty", want.is_empty, result.is_empty);
                check_field("error_code", want.error_code, result.error_code);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL double_ended_queue");
            $finish;
        end
    end

    initial
    begin
        cycles = 0;
        mismatches = 0;
        idle_pct = 0;
        held_count = 0;
        front_ptr = '0;
        back_ptr = '0;
        rst_n <= 1'b0;
        start <= 1'b0;
        cmd <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        idle_pct = 11;
        test_corner_values();
        test_empty_pops();
        test_fill_and_drain();
        test_random_mix(30);

        idle_pct = 74;
        test_random_mix(30);
        test_fill_and_drain();

        idle_pct = 0;
        test_random_mix(30);
        test_fill_and_drain();
        test_random_mix(30);

        start <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("PASS double_ended_queue");
        else
            $display("FAIL double_ended_queue");
        $finish;
    end
endmodule
